>>> design/ssrl_pkg.sv
// Shared types and constants for the servo slew rate limiter.
`timescale 1ns / 1ps
`default_nettype none

package ssrl_pkg;

	// Field widths.
	localparam int AngleW = 16;
	localparam int IdxW   = 3;

	// Configuration register indexes.
	localparam logic [IdxW-1:0] REG_LID_OPEN   = 3'd0;
	localparam logic [IdxW-1:0] REG_LID_CLOSE  = 3'd1;
	localparam logic [IdxW-1:0] REG_LID_STEP   = 3'd2;
	localparam logic [IdxW-1:0] REG_AUX_OPEN   = 3'd3;
	localparam logic [IdxW-1:0] REG_AUX_CLOSE  = 3'd4;
	localparam logic [IdxW-1:0] REG_AUX_STEP   = 3'd5;
	localparam logic [IdxW-1:0] REG_CH_ENABLE  = 3'd6;

	// Configuration reset values.
	localparam logic [AngleW-1:0] RST_LID_OPEN  = 16'd23040;
	localparam logic [AngleW-1:0] RST_LID_CLOSE = 16'd0;
	localparam logic [AngleW-1:0] RST_LID_STEP  = 16'd307;
	localparam logic [AngleW-1:0] RST_AUX_OPEN  = 16'd0;
	localparam logic [AngleW-1:0] RST_AUX_CLOSE = 16'd0;
	localparam logic [AngleW-1:0] RST_AUX_STEP  = 16'd307;
	localparam logic [1:0]        RST_CH_ENABLE = 2'd1;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_TICK  = 3'd0,
		REQ_SET   = 3'd1,
		REQ_STOP  = 3'd2,
		REQ_OPEN  = 3'd3,
		REQ_CLOSE = 3'd4
	} req_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_DRIVE   = 2'd0,
		KIND_STARTED = 2'd1,
		KIND_DONE    = 2'd2
	} kind_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MOVE,
		ST_DONE
	} state_t;

	// Source of the angle in an emitted result.
	typedef enum logic [1:0] {
		ANG_GOAL_NEW,
		ANG_POS_NEXT,
		ANG_POS
	} ang_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     cur_load;
		logic     cur_val;
		logic     goal_load;
		logic     motion_set;
		logic     motion_clr;
		logic     pos_move;
		logic     emit;
		kind_t    kind;
		logic     last;
		ang_sel_t ang_sel;
	} ssrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		req_t req;
		logic cur_ch;
		logic cur_motion;
		logic act0;
		logic act1;
		logic snap;
		logic out_free;
	} ssrl_stat_t;

endpackage

`default_nettype wire

>>> design/servo_slew_rate_limiter.sv
// Top level of the two-channel servo slew rate limiter.
//
//  Channel  Direction  Handshake             Payload
//  cmd      in         cmd_valid/cmd_stall   req_type, channel, goal_angle
//  res      out        res_valid/res_stall   kind, out_channel, angle, last
//  cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A command beat is taken while the controller is idle and decoded in the next
// cycle. A tick walks the enabled, moving channels in order, one result beat per
// cycle while the result port is not stalled; the single result register sets
// this pace. Reset clears both channels to position 0, idle, and loads the default
// config. cmd_stall stays high from the cycle after a beat is taken until the
// command is done; for a command with results, until its last result has been
// loaded into the result register.
`timescale 1ns / 1ps
`default_nettype none

module servo_slew_rate_limiter
	import ssrl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire logic [2:0]        req_type,
	input  wire logic              channel,
	input  wire logic [AngleW-1:0] goal_angle,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [1:0]             kind,
	output logic                   out_channel,
	output logic [AngleW-1:0]      angle,
	output logic                   last,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IdxW-1:0]   cfg_index,
	input  wire logic [AngleW-1:0] cfg_data
);

	ssrl_cmd_t  cmd;
	ssrl_stat_t stat;
	logic       busy;
	logic       accept;

	// Command beats are taken only while the controller is idle.
	assign cmd_stall = busy;
	assign accept    = cmd_valid && !busy;
	assign cfg_ready = 1'b1;

	ssrl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	ssrl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (req_type),
		.channel      (channel),
		.goal_angle   (goal_angle),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.res_stall    (res_stall),
		.res_valid    (res_valid),
		.kind         (kind),
		.out_channel  (out_channel),
		.angle        (angle),
		.last         (last)
	);

endmodule

`default_nettype wire

>>> design/ssrl_ctrl.sv
// Controller state machine that sequences commands and tick walks.
`timescale 1ns / 1ps
`default_nettype none

module ssrl_ctrl
	import ssrl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire ssrl_stat_t stat,
	output logic            busy,
	output ssrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	logic   more;

	// Channel 1 still has work after the current channel 0 move.
	assign more = !stat.cur_ch && stat.act1;
	assign busy = (state_q != ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.kind       = KIND_DRIVE;
		cmd.ang_sel    = ANG_POS_NEXT;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.req)
					REQ_TICK: begin
						if (stat.act0) begin
							cmd.cur_load = 1'b1;
							cmd.cur_val  = 1'b0;
							state_d      = ST_MOVE;
						end else if (stat.act1) begin
							cmd.cur_load = 1'b1;
							cmd.cur_val  = 1'b1;
							state_d      = ST_MOVE;
						end else begin
							state_d = ST_IDLE;
						end
					end
					REQ_SET, REQ_OPEN, REQ_CLOSE: begin
						if (stat.cur_motion) begin
							cmd.goal_load = 1'b1;
							state_d       = ST_IDLE;
						end else if (stat.out_free) begin
							cmd.goal_load  = 1'b1;
							cmd.motion_set = 1'b1;
							cmd.emit       = 1'b1;
							cmd.kind       = KIND_STARTED;
							cmd.ang_sel    = ANG_GOAL_NEW;
							cmd.last       = 1'b1;
							state_d        = ST_IDLE;
						end
					end
					REQ_STOP: begin
						cmd.motion_clr = 1'b1;
						state_d        = ST_IDLE;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_MOVE: begin
				if (stat.out_free) begin
					cmd.pos_move = 1'b1;
					cmd.emit     = 1'b1;
					cmd.kind     = KIND_DRIVE;
					cmd.ang_sel  = ANG_POS_NEXT;
					if (stat.snap) begin
						cmd.motion_clr = 1'b1;
						state_d        = ST_DONE;
					end else if (more) begin
						cmd.cur_load = 1'b1;
						cmd.cur_val  = 1'b1;
					end else begin
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = KIND_DONE;
					cmd.ang_sel = ANG_POS;
					if (more) begin
						cmd.cur_load = 1'b1;
						cmd.cur_val  = 1'b1;
						state_d      = ST_MOVE;
					end else begin
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/ssrl_dp.sv
// Datapath: configuration, channel state, step arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none

module ssrl_dp
	import ssrl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [2:0]        req_type,
	input  wire logic              channel,
	input  wire logic [AngleW-1:0] goal_angle,
	input  wire logic              cfg_we,
	input  wire logic [IdxW-1:0]   cfg_index,
	input  wire logic [AngleW-1:0] cfg_data,
	input  wire ssrl_cmd_t         cmd,
	output ssrl_stat_t             stat,
	input  wire logic              res_stall,
	output logic                   res_valid,
	output logic [1:0]             kind,
	output logic                   out_channel,
	output logic [AngleW-1:0]      angle,
	output logic                   last
);

	// Configuration registers.
	logic [AngleW-1:0] lid_open_q, lid_close_q, lid_step_q;
	logic [AngleW-1:0] aux_open_q, aux_close_q, aux_step_q;
	logic [1:0]        ch_enable_q;

	// Channel state and the latched command.
	logic [AngleW-1:0] position_q [2];
	logic [AngleW-1:0] goal_q [2];
	logic [1:0]        motion_q;
	req_t              req_q;
	logic              cur_q;
	logic [AngleW-1:0] tgt_q;

	// Result register.
	logic              res_valid_q;
	kind_t             kind_q;
	logic              chan_q;
	logic [AngleW-1:0] angle_q;
	logic              last_q;

	logic [AngleW-1:0] pos_cur, goal_cur, step_cur, goal_new, mag, pos_next, ang_out;
	logic              up, snap;

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lid_open_q  <= RST_LID_OPEN;
			lid_close_q <= RST_LID_CLOSE;
			lid_step_q  <= RST_LID_STEP;
			aux_open_q  <= RST_AUX_OPEN;
			aux_close_q <= RST_AUX_CLOSE;
			aux_step_q  <= RST_AUX_STEP;
			ch_enable_q <= RST_CH_ENABLE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LID_OPEN:  lid_open_q  <= cfg_data;
				REG_LID_CLOSE: lid_close_q <= cfg_data;
				REG_LID_STEP:  lid_step_q  <= cfg_data;
				REG_AUX_OPEN:  aux_open_q  <= cfg_data;
				REG_AUX_CLOSE: aux_close_q <= cfg_data;
				REG_AUX_STEP:  aux_step_q  <= cfg_data;
				REG_CH_ENABLE: ch_enable_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Values of the selected channel.
	assign pos_cur  = position_q[cur_q];
	assign goal_cur = goal_q[cur_q];
	assign step_cur = cur_q ? aux_step_q : lid_step_q;

	// Goal that a set, open or close command loads.
	always_comb begin
		case (req_q)
			REQ_OPEN:  goal_new = cur_q ? aux_open_q : lid_open_q;
			REQ_CLOSE: goal_new = cur_q ? aux_close_q : lid_close_q;
			default:   goal_new = tgt_q;
		endcase
	end

	// One step toward the goal, or a snap when the error is within a step.
	assign up       = (goal_cur > pos_cur);
	assign mag      = up ? (goal_cur - pos_cur) : (pos_cur - goal_cur);
	assign snap     = (mag <= step_cur);
	assign pos_next = snap ? goal_cur : (up ? (pos_cur + step_cur) : (pos_cur - step_cur));

	// Latched command and channel pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= REQ_TICK;
			cur_q <= 1'b0;
			tgt_q <= '0;
		end else if (accept) begin
			req_q <= req_t'(req_type);
			cur_q <= channel;
			tgt_q <= goal_angle;
		end else if (cmd.cur_load) begin
			cur_q <= cmd.cur_val;
		end
	end

	// Channel state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q[0] <= '0;
			position_q[1] <= '0;
			goal_q[0]     <= '0;
			goal_q[1]     <= '0;
			motion_q      <= '0;
		end else begin
			if (cmd.goal_load) begin
				goal_q[cur_q] <= goal_new;
			end
			if (cmd.pos_move) begin
				position_q[cur_q] <= pos_next;
			end
			if (cmd.motion_set) begin
				motion_q[cur_q] <= 1'b1;
			end else if (cmd.motion_clr) begin
				motion_q[cur_q] <= 1'b0;
			end
		end
	end

	// Angle of the beat being emitted.
	always_comb begin
		case (cmd.ang_sel)
			ANG_GOAL_NEW: ang_out = goal_new;
			ANG_POS_NEXT: ang_out = pos_next;
			ANG_POS:      ang_out = pos_cur;
			default:      ang_out = pos_cur;
		endcase
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q  <= cmd.kind;
			chan_q  <= cur_q;
			angle_q <= ang_out;
			last_q  <= cmd.last;
		end
	end

	// Status toward the controller.
	assign stat.req        = req_q;
	assign stat.cur_ch     = cur_q;
	assign stat.cur_motion = motion_q[cur_q];
	assign stat.act0       = ch_enable_q[0] && motion_q[0];
	assign stat.act1       = ch_enable_q[1] && motion_q[1];
	assign stat.snap       = snap;
	assign stat.out_free   = !res_valid_q || !res_stall;

	assign res_valid   = res_valid_q;
	assign kind        = kind_q;
	assign out_channel = chan_q;
	assign angle       = angle_q;
	assign last        = last_q;

endmodule

`default_nettype wire

>>> design/ssrl_checker.sv
// Port-level checks for the servo slew rate limiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ssrl_checker
	import ssrl_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_stall,
	input wire logic              res_valid,
	input wire logic              res_stall,
	input wire logic [1:0]        kind,
	input wire logic              out_channel,
	input wire logic [AngleW-1:0] angle,
	input wire logic              last
);

	// A taken command beat blocks the next one while it is worked on.
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while previous one still in progress");

	// A stalled result beat holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(angle) && $stable(kind)
			&& $stable(last) && $stable(out_channel))
		else $error("stalled result beat changed");

	// A completed event is loaded as its channel's final drive beat leaves.
	a_done_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_DONE && $past(res_valid && !res_stall)
			|-> $past(kind) == KIND_DRIVE
			&& $past(out_channel) == out_channel && $past(angle) == angle)
		else $error("completed event not preceded by its final drive beat");

	// A started event is the only result of its command.
	a_started_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_STARTED |-> last)
		else $error("started event not marked last");

endmodule

bind servo_slew_rate_limiter ssrl_checker u_ssrl_checker (.*);

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the two-channel servo slew rate limiter.
`timescale 1ns / 1ps

module tb;
	import ssrl_pkg::*;

	// One result beat as it appears on the result port.
	typedef struct packed {
		logic [1:0]        kind;
		logic              ch;
		logic [AngleW-1:0] angle;
		logic              last;
	} beat_t;

	// How a directed row is handled: a predicted command, a command known to give
	// no beat, a command known to give one beat, or a register write.
	typedef enum logic [1:0] {
		ROW_CMD,
		ROW_CMD_NONE,
		ROW_CMD_ONE,
		ROW_CFG
	} row_e;

	// For a register write, op holds the register index and val the data.
	typedef struct packed {
		row_e              mode;
		logic [2:0]        op;
		logic              ch;
		logic [AngleW-1:0] val;
		beat_t             want;
	} row_t;

	localparam int RAND_PHASES = 5;
	localparam int PHASE_ITEMS = 40;
	localparam int SETTLE      = 8;
	localparam int CYCLE_LIMIT = 200000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cmd_valid    = 1'b0;
	logic              cmd_stall;
	logic [2:0]        req_type     = '0;
	logic              channel      = 1'b0;
	logic [AngleW-1:0] goal_angle   = '0;
	logic              res_valid;
	logic              res_stall    = 1'b0;
	logic [1:0]        kind;
	logic              out_channel;
	logic [AngleW-1:0] angle;
	logic              last;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [IdxW-1:0]   cfg_index    = '0;
	logic [AngleW-1:0] cfg_data     = '0;

	// Shadow of the block's configuration and channel state.
	logic [AngleW-1:0] lid_open_q, lid_close_q, lid_step_q;
	logic [AngleW-1:0] aux_open_q, aux_close_q, aux_step_q;
	logic [1:0]        enable_q;
	logic [AngleW-1:0] ramp_pos [2];
	logic [AngleW-1:0] ramp_goal [2];
	logic              ramp_moving [2];

	beat_t beats_due [$];
	beat_t fresh_beats [$];
	beat_t seen_due;
	row_t  dir_plan [$];

	int fails  = 0;
	int cycles = 0;
	bit calm   = 1'b0;

	servo_slew_rate_limiter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.req_type    (req_type),
		.channel     (channel),
		.goal_angle  (goal_angle),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.kind        (kind),
		.out_channel (out_channel),
		.angle       (angle),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// Give up if the run hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Compare every accepted result beat with the oldest one due, then pick the
	// stall for the next cycle.
	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			if (beats_due.size() == 0) begin
				$error("result beat with none due: kind %0d channel %0d angle %0d",
					kind, out_channel, angle);
				fails++;
			end else begin
				seen_due = beats_due.pop_front();
				if (kind !== seen_due.kind) begin
					$error("kind: expected %0d, got %0d", seen_due.kind, kind);
					fails++;
				end
				if (out_channel !== seen_due.ch) begin
					$error("out_channel: expected %0d, got %0d", seen_due.ch, out_channel);
					fails++;
				end
				if (angle !== seen_due.angle) begin
					$error("angle: expected %0d, got %0d", seen_due.angle, angle);
					fails++;
				end
				if (last !== seen_due.last) begin
					$error("last: expected %0d, got %0d", seen_due.last, last);
					fails++;
				end
			end
		end
		res_stall <= !calm && ($urandom_range(99) < 19);
	end

	function automatic beat_t mk_beat(kind_t k, logic c, logic [AngleW-1:0] a, logic l);
		beat_t b;
		b.kind  = k;
		b.ch    = c;
		b.angle = a;
		b.last  = l;
		return b;
	endfunction

	function automatic row_t cmd_row(row_e m, logic [2:0] op, logic c,
			logic [AngleW-1:0] v, beat_t w);
		row_t r;
		r.mode = m;
		r.op   = op;
		r.ch   = c;
		r.val  = v;
		r.want = w;
		return r;
	endfunction

	function automatic logic [AngleW-1:0] pick_angle();
		case ($urandom_range(9))
			0: return '0;
			1: return 16'd46080;
			default: return 16'($urandom_range(46080));
		endcase
	endfunction

	function automatic logic [AngleW-1:0] pick_step();
		case ($urandom_range(9))
			0: return '0;
			1: return 16'd46080;
			default: return 16'($urandom_range(4000, 1));
		endcase
	endfunction

	// Load a new goal; an idle channel starts moving and announces it.
	task automatic retarget(logic c, logic [AngleW-1:0] g);
		ramp_goal[c] = g;
		if (!ramp_moving[c]) begin
			ramp_moving[c] = 1'b1;
			fresh_beats.push_back(mk_beat(KIND_STARTED, c, g, 1'b0));
		end
	endtask

	// Work out the beats one command causes and advance the shadow state.
	task automatic servo_ramp_predict(logic [2:0] op, logic c, logic [AngleW-1:0] tgt);
		int err;
		int mag;
		int stp;
		fresh_beats.delete();
		case (op)
			REQ_TICK: begin
				for (int k = 0; k < 2; k++) begin
					if (enable_q[k] && ramp_moving[k]) begin
						stp = (k == 1) ? int'(aux_step_q) : int'(lid_step_q);
						err = int'(ramp_goal[k]) - int'(ramp_pos[k]);
						mag = (err < 0) ? -err : err;
						if (mag <= stp) begin
							// Close enough: snap to the goal and finish.
							ramp_pos[k] = ramp_goal[k];
							ramp_moving[k] = 1'b0;
							fresh_beats.push_back(mk_beat(KIND_DRIVE, k[0], ramp_pos[k], 1'b0));
							fresh_beats.push_back(mk_beat(KIND_DONE, k[0], ramp_pos[k], 1'b0));
						end else begin
							ramp_pos[k] = (err > 0) ? 16'(int'(ramp_pos[k]) + stp)
								: 16'(int'(ramp_pos[k]) - stp);
							fresh_beats.push_back(mk_beat(KIND_DRIVE, k[0], ramp_pos[k], 1'b0));
						end
					end
				end
			end
			REQ_SET:   retarget(c, tgt);
			REQ_STOP:  ramp_moving[c] = 1'b0;
			REQ_OPEN:  retarget(c, c ? aux_open_q : lid_open_q);
			REQ_CLOSE: retarget(c, c ? aux_close_q : lid_close_q);
			default: ;
		endcase
	endtask

	// Hold one command beat until it is taken, then queue what it must cause.
	task automatic send_cmd(logic [2:0] op, logic c, logic [AngleW-1:0] v,
			row_e mode, beat_t want);
		beat_t b;
		cmd_valid    <= 1'b1;
		req_type     <= op;
		channel      <= c;
		goal_angle   <= v;
		do @(posedge clk); while (cmd_stall);
		servo_ramp_predict(op, c, v);
		case (mode)
			ROW_CMD_NONE: ;
			ROW_CMD_ONE: beats_due.push_back(want);
			default: begin
				for (int i = 0; i < fresh_beats.size(); i++) begin
					b = fresh_beats[i];
					b.last = (i == fresh_beats.size() - 1);
					beats_due.push_back(b);
				end
			end
		endcase
	endtask

	// Random gap on the command side.
	task automatic cmd_gap();
		if (!calm && $urandom_range(99) < 19) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every beat still due.
	task automatic drain();
		cmd_valid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
	endtask

	// Drain and let any command that gives no beat finish inside the block.
	task automatic quiesce();
		drain();
		repeat (SETTLE) @(posedge clk);
	endtask

	// One register write beat; the caller lowers cfg_valid after the batch.
	task automatic write_reg(logic [IdxW-1:0] idx, logic [AngleW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LID_OPEN:  lid_open_q  = data;
			REG_LID_CLOSE: lid_close_q = data;
			REG_LID_STEP:  lid_step_q  = data;
			REG_AUX_OPEN:  aux_open_q  = data;
			REG_AUX_CLOSE: aux_close_q = data;
			REG_AUX_STEP:  aux_step_q  = data;
			REG_CH_ENABLE: enable_q    = data[1:0];
			default: ;
		endcase
	endtask

	initial begin
		bit          in_cfg;
		row_t        r;
		int          roll;
		int          n;
		logic [2:0]  op;
		logic [AngleW-1:0] v;

		// Shadow state after reset.
		lid_open_q  = RST_LID_OPEN;
		lid_close_q = RST_LID_CLOSE;
		lid_step_q  = RST_LID_STEP;
		aux_open_q  = RST_AUX_OPEN;
		aux_close_q = RST_AUX_CLOSE;
		aux_step_q  = RST_AUX_STEP;
		enable_q    = RST_CH_ENABLE;
		for (int k = 0; k < 2; k++) begin
			ramp_pos[k]    = '0;
			ramp_goal[k]   = '0;
			ramp_moving[k] = 1'b0;
		end

		// Directed plan, first under the reset configuration.
		dir_plan.push_back(cmd_row(ROW_CMD_NONE, REQ_TICK, 1'b0, '0, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_NONE, 3'd5, 1'b1, 16'hFFFF, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_NONE, 3'd7, 1'b0, '0, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_ONE, REQ_OPEN, 1'b0, '0,
			mk_beat(KIND_STARTED, 1'b0, 16'd23040, 1'b1)));
		dir_plan.push_back(cmd_row(ROW_CMD_NONE, REQ_SET, 1'b0, 16'd46080, '0));
		dir_plan.push_back(cmd_row(ROW_CMD, REQ_TICK, 1'b1, 16'd46080, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_ONE, REQ_SET, 1'b1, 16'd46080,
			mk_beat(KIND_STARTED, 1'b1, 16'd46080, 1'b1)));
		dir_plan.push_back(cmd_row(ROW_CMD, REQ_TICK, 1'b0, '0, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_NONE, REQ_STOP, 1'b0, '0, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_NONE, REQ_TICK, 1'b0, '0, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_ONE, REQ_CLOSE, 1'b0, '0,
			mk_beat(KIND_STARTED, 1'b0, 16'd0, 1'b1)));
		dir_plan.push_back(cmd_row(ROW_CMD, REQ_TICK, 1'b0, '0, '0));
		dir_plan.push_back(cmd_row(ROW_CMD, REQ_TICK, 1'b0, '0, '0));
		// Both channels on, zero step on the lid, full-span step on the aux.
		dir_plan.push_back(cmd_row(ROW_CFG, REG_CH_ENABLE, 1'b0, 16'd3, '0));
		dir_plan.push_back(cmd_row(ROW_CFG, REG_LID_STEP, 1'b0, 16'd0, '0));
		dir_plan.push_back(cmd_row(ROW_CFG, REG_AUX_STEP, 1'b0, 16'd46080, '0));
		dir_plan.push_back(cmd_row(ROW_CFG, REG_LID_OPEN, 1'b0, 16'd46080, '0));
		dir_plan.push_back(cmd_row(ROW_CFG, REG_AUX_CLOSE, 1'b0, 16'd46080, '0));
		dir_plan.push_back(cmd_row(ROW_CMD, REQ_TICK, 1'b0, '0, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_ONE, REQ_OPEN, 1'b0, '0,
			mk_beat(KIND_STARTED, 1'b0, 16'd46080, 1'b1)));
		dir_plan.push_back(cmd_row(ROW_CMD, REQ_TICK, 1'b0, '0, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_ONE, REQ_SET, 1'b1, 16'd0,
			mk_beat(KIND_STARTED, 1'b1, 16'd0, 1'b1)));
		dir_plan.push_back(cmd_row(ROW_CMD, REQ_TICK, 1'b0, '0, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_NONE, REQ_SET, 1'b0, 16'd0, '0));
		dir_plan.push_back(cmd_row(ROW_CMD_ONE, REQ_CLOSE, 1'b1, '0,
			mk_beat(KIND_STARTED, 1'b1, 16'd46080, 1'b1)));
		dir_plan.push_back(cmd_row(ROW_CMD, REQ_TICK, 1'b0, '0, '0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed plan.
		in_cfg = 1'b0;
		foreach (dir_plan[i]) begin
			r = dir_plan[i];
			if (r.mode == ROW_CFG) begin
				if (!in_cfg) begin
					quiesce();
					in_cfg = 1'b1;
				end
				write_reg(r.op, r.val);
			end else begin
				if (in_cfg) begin
					cfg_valid <= 1'b0;
					in_cfg = 1'b0;
				end
				cmd_gap();
				send_cmd(r.op, r.ch, r.val, r.mode, r.want);
			end
		end

		// Random phases, each under a fresh configuration.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			quiesce();
			write_reg(REG_LID_OPEN, pick_angle());
			write_reg(REG_LID_CLOSE, pick_angle());
			write_reg(REG_LID_STEP, pick_step());
			write_reg(REG_AUX_OPEN, pick_angle());
			write_reg(REG_AUX_CLOSE, pick_angle());
			write_reg(REG_AUX_STEP, pick_step());
			write_reg(REG_CH_ENABLE, ($urandom_range(9) < 6) ? 16'd3
				: 16'($urandom_range(3)));
			cfg_valid <= 1'b0;
			calm = (ph == 2);
			n = 0;
			while (n < PHASE_ITEMS) begin
				roll = $urandom_range(99);
				v = 16'($urandom_range(46080));
				if (roll < 50) begin
					op = REQ_TICK;
				end else if (roll < 68) begin
					op = REQ_SET;
					v = pick_angle();
				end else if (roll < 78) begin
					op = REQ_OPEN;
				end else if (roll < 88) begin
					op = REQ_CLOSE;
				end else if (roll < 95) begin
					op = REQ_STOP;
				end else begin
					op = 3'($urandom_range(7, 5));
				end
				if (op <= REQ_CLOSE) n++;
				// Once, hold off until the block has answered everything.
				if (ph == 3 && n == 20) drain();
				cmd_gap();
				send_cmd(op, 1'($urandom_range(1)), v, ROW_CMD, '0);
			end
		end
		calm = 1'b0;

		drain();
		repeat (SETTLE + 4) @(posedge clk);
		if (fails == 0 && beats_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/ssrl_pkg.sv
design/ssrl_ctrl.sv
design/ssrl_dp.sv
design/servo_slew_rate_limiter.sv
design/ssrl_checker.sv
verif/tb.sv
